// ----- design/mrb_pkg.sv -----
// Shared types, constants and helper functions for the modal resonator bank.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none
package mrb_pkg;
	localparam int MAX_MODES  = 64;
	localparam int IDX_W      = $clog2(MAX_MODES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COEF_WIDTH = 32;
	localparam int ACC_W      = 48;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_RENDER  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_FREQ = 3'd0,
		REG_MAX_FREQ = 3'd1,
		REG_ACTIVE   = 3'd2,
		REG_SCALE    = 3'd3,
		REG_PERIOD   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MODE,
		ST_PROD,
		ST_SCALE,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             restart;
		logic             start;
		logic             rd;
		logic             mode;
		logic             finish;
		logic             scale;
		logic             round;
		logic [IDX_W-1:0] addr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             armed;
		logic [CNT_W-1:0] count;
		logic             stop;
	} status_t;

	// Clear the low coefficient bits below COEF_WIDTH.
	function automatic logic signed [31:0] coef_mask(input logic signed [31:0] v);
		logic [31:0] m;
		m = '1;
		m = m << (32 - COEF_WIDTH);
		return v & m;
	endfunction

	// Round half up by 30 bits and saturate to a signed 32-bit value.
	function automatic logic signed [31:0] q30_sat(input logic signed [65:0] s);
		logic signed [65:0] r;
		logic signed [35:0] t;
		r = s + 66'sd536870912;
		t = r[65:30];
		if (t > 36'sd2147483647)
			return coef_mask(32'sh7fffffff);
		else if (t < -36'sd2147483648)
			return coef_mask(32'sh80000000);
		else
			return coef_mask(t[31:0]);
	endfunction
endpackage
`default_nettype wire

// ----- design/modal_resonator_bank_render.sv -----
// Modal resonator bank: a render item walks the modes, each by memory read,
// products and write back, ending early at the first mode above the band.
// With the modes read, scaling and rounding follow and then out_valid rises;
// the next item is taken once the render is back in idle, later only while
// an older result is stalled. Load, restart and renders that give no result
// stay in idle, so the input stays open. Reset clears the armed flag, the
// elapsed time and the registers to their defaults; mode memory is undefined.
`default_nettype none
module modal_resonator_bank_render (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         operation,
	input  wire logic [5:0]         mode_index,
	input  wire logic signed [31:0] first_state_re,
	input  wire logic signed [31:0] first_state_im,
	input  wire logic signed [31:0] second_state_re,
	input  wire logic signed [31:0] second_state_im,
	input  wire logic signed [31:0] first_pole_re,
	input  wire logic signed [31:0] first_pole_im,
	input  wire logic signed [31:0] second_pole_re,
	input  wire logic signed [31:0] second_pole_im,
	input  wire logic [15:0]        natural_freq,
	input  wire logic               critical,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      sample,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import mrb_pkg::*;

	logic [15:0] min_q, max_q, scale_q;
	logic [6:0]  active_q;
	logic [31:0] period_q;
	cmd_t        cmd;
	status_t     status;
	logic        out_vld_q;
	logic signed [23:0] out_q;
	logic signed [23:0] dp_sample;
	logic        dp_vld;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= 16'd20;
			max_q    <= 16'd20000;
			active_q <= 7'd64;
			scale_q  <= 16'd256;
			period_q <= 32'd22906492;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_FREQ: min_q    <= cfg_data[15:0];
				REG_MAX_FREQ: max_q    <= cfg_data[15:0];
				REG_ACTIVE:   active_q <= cfg_data[6:0];
				REG_SCALE:    scale_q  <= cfg_data[15:0];
				REG_PERIOD:   period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrb_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .operation, .in_stall,
		.out_busy (out_vld_q && out_stall),
		.status, .cmd
	);

	mrb_dp u_dp (
		.clk, .arst_n, .cmd, .status, .mode_index,
		.first_state_re, .first_state_im, .second_state_re, .second_state_im,
		.first_pole_re, .first_pole_im, .second_pole_re, .second_pole_im,
		.natural_freq, .critical,
		.min_freq (min_q), .max_freq (max_q), .active_modes (active_q),
		.sound_scale (scale_q), .sample_period (period_q),
		.sample (dp_sample), .sample_vld (dp_vld)
	);

	// Output register: holds one result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (dp_vld)
			out_vld_q <= 1'b1;
		else if (!out_stall)
			out_vld_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (dp_vld)
			out_q <= dp_sample;
	end

	assign out_valid = out_vld_q;
	assign sample    = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample)) else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_vld |-> !(out_vld_q && out_stall)) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_vld |=> out_valid) else $error("result not presented");
endmodule
`default_nettype wire

// ----- design/mrb_ctrl.sv -----
// Controller state machine of the modal resonator bank.
// Depends on mrb_pkg; drives datapath commands from the status it sees.
`default_nettype none
module mrb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         operation,
	output logic                    in_stall,
	input  wire logic               out_busy,
	input  wire mrb_pkg::status_t   status,
	output mrb_pkg::cmd_t           cmd
);
	import mrb_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] k_q, k_nx;
	logic             acc_in;
	op_t              op;

	assign op = op_t'(operation);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_nx;
			k_q     <= k_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		k_nx     = k_q;
		cmd      = '0;
		cmd.addr = k_q[IDX_W-1:0];
		in_stall = 1'b1;
		acc_in   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				acc_in   = in_valid;
				if (acc_in) begin
					case (op)
						OP_LOAD:    cmd.load = 1'b1;
						OP_RESTART: cmd.restart = 1'b1;
						OP_RENDER: begin
							if (status.armed && status.count != '0) begin
								cmd.start = 1'b1;
								k_nx      = '0;
								state_nx  = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				// Issue the memory read for mode k.
				cmd.rd   = 1'b1;
				state_nx = ST_MODE;
			end
			ST_MODE: begin
				// Registered read data is present: check the band and start products.
				cmd.mode = 1'b1;
				state_nx = ST_PROD;
			end
			ST_PROD: begin
				// Accumulate, write back the decayed states, then step or finish.
				cmd.finish = 1'b1;
				if (status.stop || k_q + 1'b1 >= status.count)
					state_nx = ST_SCALE;
				else begin
					k_nx     = k_q + 1'b1;
					state_nx = ST_READ;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.round = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_READ) else $error("render did not start walk");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_MODE) else $error("read not followed by mode");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("input open while busy");
endmodule
`default_nettype wire

// ----- design/mrb_dp.sv -----
// Datapath of the modal resonator bank: mode memories, multipliers,
// accumulator, elapsed time and output scaling. Depends on mrb_pkg.
`default_nettype none
module mrb_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mrb_pkg::cmd_t       cmd,
	output mrb_pkg::status_t         status,
	input  wire logic [5:0]          mode_index,
	input  wire logic signed [31:0]  first_state_re,
	input  wire logic signed [31:0]  first_state_im,
	input  wire logic signed [31:0]  second_state_re,
	input  wire logic signed [31:0]  second_state_im,
	input  wire logic signed [31:0]  first_pole_re,
	input  wire logic signed [31:0]  first_pole_im,
	input  wire logic signed [31:0]  second_pole_re,
	input  wire logic signed [31:0]  second_pole_im,
	input  wire logic [15:0]         natural_freq,
	input  wire logic                critical,
	input  wire logic [15:0]         min_freq,
	input  wire logic [15:0]         max_freq,
	input  wire logic [6:0]          active_modes,
	input  wire logic [15:0]         sound_scale,
	input  wire logic [31:0]         sample_period,
	output logic signed [23:0]       sample,
	output logic                     sample_vld
);
	import mrb_pkg::*;

	// One wide entry per mode: four complex values, frequency, flag.
	localparam int ENT_W = 8 * 32 + 16 + 1;

	logic [ENT_W-1:0] mem [MAX_MODES];
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic signed [31:0] s1r, s1i, s2r, s2i, p1r, p1i, p2r, p2i;
	logic [15:0]        fr;
	logic               cr;
	assign {s1r, s1i, s2r, s2i, p1r, p1i, p2r, p2i, fr, cr} = rd_q;

	logic               armed_q;
	logic [47:0]        time_q;
	logic signed [ACC_W-1:0] acc_q;
	logic               stop_q;
	logic signed [63:0] pr1_q [4];
	logic signed [63:0] pr2_q [4];
	logic signed [63:0] crit_q;
	logic               visit_q, crit_f_q;
	logic [ENT_W-1:0]   keep_q;
	logic signed [64:0] scaled_q;
	logic signed [23:0] sample_q;
	logic               vld_q;
	logic [CNT_W-1:0]   cnt;
	logic signed [ACC_W-1:0] term;
	logic signed [32:0] tq;
	logic               skip, brk;

	assign cnt = (active_modes > 7'(MAX_MODES)) ? CNT_W'(MAX_MODES) : active_modes[CNT_W-1:0];
	assign status.armed = armed_q;
	assign status.count = cnt;
	assign status.stop  = stop_q;
	// Elapsed time cut to Q8.24 for the critical term.
	assign tq   = {1'b0, time_q[47:16]};
	assign skip = fr < min_freq;
	assign brk  = !skip && fr > max_freq;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.addr;
		wr_data = keep_q;
		if (cmd.load) begin
			wr_en   = 32'(mode_index) < MAX_MODES;
			wr_addr = mode_index[IDX_W-1:0];
			wr_data = {coef_mask(first_state_re), coef_mask(first_state_im),
				coef_mask(second_state_re), coef_mask(second_state_im),
				coef_mask(first_pole_re), coef_mask(first_pole_im),
				coef_mask(second_pole_re), coef_mask(second_pole_im),
				natural_freq, critical};
		end else if (cmd.finish && visit_q) begin
			wr_en   = 1'b1;
			wr_data = {q30_sat(66'(pr1_q[0]) - 66'(pr1_q[1])),
				q30_sat(66'(pr1_q[2]) + 66'(pr1_q[3])),
				q30_sat(66'(pr2_q[0]) - 66'(pr2_q[1])),
				q30_sat(66'(pr2_q[2]) + 66'(pr2_q[3])),
				keep_q[ENT_W-129:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd)
			rd_q <= mem[cmd.addr];
	end

	// Mode term and products; the crit product is completed in the next state.
	always_ff @(posedge clk) begin
		if (cmd.mode) begin
			pr1_q[0] <= 64'(s1r) * 64'(p1r);
			pr1_q[1] <= 64'(s1i) * 64'(p1i);
			pr1_q[2] <= 64'(s1r) * 64'(p1i);
			pr1_q[3] <= 64'(s1i) * 64'(p1r);
			pr2_q[0] <= 64'(s2r) * 64'(p2r);
			pr2_q[1] <= 64'(s2i) * 64'(p2i);
			pr2_q[2] <= 64'(s2r) * 64'(p2i);
			pr2_q[3] <= 64'(s2i) * 64'(p2r);
			crit_q   <= 64'(s2r) * 64'(tq);
			crit_f_q <= cr;
			keep_q   <= rd_q;
		end
		if (cmd.scale)
			scaled_q <= 65'(acc_q) * $signed({1'b0, sound_scale});
	end

	always_comb begin
		if (crit_f_q)
			term = ACC_W'($signed(keep_q[ENT_W-1 -: 32]))
				+ ACC_W'((crit_q + 64'sd8388608) >>> 24);
		else
			term = ACC_W'($signed(keep_q[ENT_W-1 -: 32]))
				+ ACC_W'($signed(keep_q[ENT_W-33 -: 32]))
				+ ACC_W'($signed(keep_q[ENT_W-65 -: 32]))
				+ ACC_W'($signed(keep_q[ENT_W-97 -: 32]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			time_q  <= '0;
			acc_q   <= '0;
			stop_q  <= 1'b0;
			visit_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= 1'b0;
			if (cmd.restart) begin
				armed_q <= 1'b1;
				time_q  <= '0;
			end
			if (cmd.start) begin
				acc_q  <= '0;
				stop_q <= 1'b0;
			end
			if (cmd.mode) begin
				visit_q <= !skip && !brk;
				stop_q  <= brk;
			end
			if (cmd.finish && visit_q) begin
				acc_q <= acc_q + term;
			end
			if (cmd.scale) begin
				if ({1'b0, time_q} + 49'(sample_period) > 49'h0ffff_ffff_ffff)
					time_q <= '1;
				else
					time_q <= time_q + 48'(sample_period);
				if (acc_q > 48'sh4000_0000_0000)
					acc_q <= 48'sh4000_0000_0000;
				else if (acc_q < -48'sh4000_0000_0000)
					acc_q <= -48'sh4000_0000_0000;
			end
			if (cmd.round)
				vld_q <= 1'b1;
		end
	end

	// Sixty-four modes sum to less than 2^46 in magnitude, so the clamp never
	// changes acc_q and scaling it directly gives the clamped product.
	logic signed [64:0] rnd;
	logic signed [49:0] sh;
	assign rnd = scaled_q + 65'sd16384;
	assign sh  = rnd[64:15];
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			if (sh > 50'sd8388607)
				sample_q <= 24'sh7fffff;
			else if (sh < -50'sd8388608)
				sample_q <= 24'sh800000;
			else
				sample_q <= sh[23:0];
		end
	end

	assign sample     = sample_q;
	assign sample_vld = vld_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> armed_q && time_q == '0) else $error("restart failed");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |=> sample_vld) else $error("no result after round");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.finish) else $error("load during walk");
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for modal_resonator_bank_render: random and directed mode loads,
// restarts and renders. A predictor models each sample, and every sample
// transfer is checked against it. Depends on mrb_pkg and the RTL top only.
`timescale 1ns / 1ps
module tb_top;
	import mrb_pkg::*;

	// One input item, one field per item input port of the block.
	typedef struct {
		op_t                op;
		logic [5:0]         idx;
		logic signed [31:0] fsr, fsi, ssr, ssi;
		logic signed [31:0] fpr, fpi, spr, spi;
		logic [15:0]        freq;
		logic               crit;
	} mode_item_t;

	localparam int STALL_LIMIT = 20000; // cycles with no transfer at all
	localparam int DRAIN_WAIT  = 260;   // covers a full 64-mode walk

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mode_item_t cur;
	logic out_valid;
	logic out_stall;
	logic signed [23:0] sample;
	logic cfg_valid;
	logic cfg_ready;
	reg_idx_t cfg_index;
	logic [31:0] cfg_data;

	modal_resonator_bank_render u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(cur.op), .mode_index(cur.idx),
		.first_state_re(cur.fsr), .first_state_im(cur.fsi),
		.second_state_re(cur.ssr), .second_state_im(cur.ssi),
		.first_pole_re(cur.fpr), .first_pole_im(cur.fpi),
		.second_pole_re(cur.spr), .second_pole_im(cur.spi),
		.natural_freq(cur.freq), .critical(cur.crit),
		.out_valid(out_valid), .out_stall(out_stall), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pending input items, filled by the stimulus process, drained by the driver.
	mode_item_t item_q[$];
	// Samples the predictor expects, oldest first.
	logic signed [23:0] sample_q[$];

	int mismatches = 0;
	int unexpected = 0;
	int n_samples = 0;
	int n_items = 0;
	int idle_cycles = 0;
	logic calm; // when set, neither side idles

	// Predictor copy of the bank. Only entries that were loaded are ever read.
	logic signed [31:0] p_fsr[64], p_fsi[64], p_ssr[64], p_ssi[64];
	logic signed [31:0] p_fpr[64], p_fpi[64], p_spr[64], p_spi[64];
	logic [15:0]        p_freq[64];
	logic               p_crit[64];
	logic [47:0]        p_elapsed;
	logic               p_armed;
	// Predictor copy of the registers, reset defaults.
	logic [15:0] p_lo_freq = 16'd20;
	logic [15:0] p_hi_freq = 16'd20000;
	logic [6:0]  p_active  = 7'd64;
	logic [15:0] p_gain    = 16'd256;
	logic [31:0] p_period  = 32'd22906492;

	// Round a sum of Q4.60 products half up to Q2.30, saturate and drop the unused low bits.
	function automatic logic signed [31:0] to_q30(input logic signed [65:0] s);
		logic signed [65:0] r;
		logic [31:0] v;
		r = (s + 66'sd536870912) >>> 30;
		if (r > 66'sd2147483647)
			v = 32'h7fffffff;
		else if (r < -66'sd2147483648)
			v = 32'h80000000;
		else
			v = r[31:0];
		return v & ~((32'd1 << (32 - COEF_WIDTH)) - 32'd1);
	endfunction

	function automatic logic signed [31:0] trim_coef(input logic signed [31:0] v);
		return v & ~((32'd1 << (32 - COEF_WIDTH)) - 32'd1);
	endfunction

	// One decay step of a complex state: state times pole.
	task automatic decay(inout logic signed [31:0] sr, inout logic signed [31:0] si,
			input logic signed [31:0] pr, input logic signed [31:0] pi);
		logic signed [63:0] ac, bd, ad, bc;
		ac = sr * pr;
		bd = si * pi;
		ad = sr * pi;
		bc = si * pr;
		sr = to_q30(66'(ac) - 66'(bd));
		si = to_q30(66'(ad) + 66'(bc));
	endtask

	// Apply one accepted item to the predicted bank; an armed render with active modes queues a sample.
	task automatic bank_step(input mode_item_t it);
		int n;
		logic signed [71:0] acc;
		logic signed [65:0] p;
		logic signed [71:0] v;
		logic [48:0] e;
		case (it.op)
			OP_LOAD: begin
				p_fsr[it.idx] = trim_coef(it.fsr);
				p_fsi[it.idx] = trim_coef(it.fsi);
				p_ssr[it.idx] = trim_coef(it.ssr);
				p_ssi[it.idx] = trim_coef(it.ssi);
				p_fpr[it.idx] = trim_coef(it.fpr);
				p_fpi[it.idx] = trim_coef(it.fpi);
				p_spr[it.idx] = trim_coef(it.spr);
				p_spi[it.idx] = trim_coef(it.spi);
				p_freq[it.idx] = it.freq;
				p_crit[it.idx] = it.crit;
			end
			OP_RESTART: begin
				p_elapsed = '0;
				p_armed = 1'b1;
			end
			OP_RENDER: begin
				n = (p_active > MAX_MODES) ? MAX_MODES : int'(p_active);
				if (p_armed && n != 0) begin
					acc = '0;
					for (int k = 0; k < n; k++) begin
						if (p_freq[k] < p_lo_freq)
							continue;
						if (p_freq[k] > p_hi_freq)
							break;
						if (p_crit[k]) begin
							// Elapsed time cut to Q8.24 scales the second state.
							p = p_ssr[k] * $signed({1'b0, p_elapsed[47:16]});
							acc += p_fsr[k] + ((p + 66'sd8388608) >>> 24);
						end else begin
							acc += p_fsr[k] + p_fsi[k] + p_ssr[k] + p_ssi[k];
						end
						decay(p_fsr[k], p_fsi[k], p_fpr[k], p_fpi[k]);
						decay(p_ssr[k], p_ssi[k], p_spr[k], p_spi[k]);
					end
					e = p_elapsed + p_period;
					p_elapsed = e[48] ? 48'hffff_ffff_ffff : e[47:0];
					if (acc > (72'sd1 <<< 46))
						acc = 72'sd1 <<< 46;
					if (acc < -(72'sd1 <<< 46))
						acc = -(72'sd1 <<< 46);
					v = (acc * $signed({1'b0, p_gain}) + 72'sd16384) >>> 15;
					if (v > 72'sd8388607)
						v = 72'sd8388607;
					if (v < -72'sd8388608)
						v = -72'sd8388608;
					sample_q.push_back(v[23:0]);
				end
			end
			default: ; // an unknown operation leaves everything as it was
		endcase
	endtask

	// Driver: presents queued items and holds each until its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				bank_step(cur);
				n_items++;
			end
			if (!in_valid || !in_stall) begin
				if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
					cur <= item_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and a check of every sample transfer.
	always @(posedge clk or negedge arst_n) begin
		logic signed [23:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && $urandom_range(0, 99) < 11;
			if (out_valid && !out_stall) begin
				n_samples++;
				if (sample_q.size() == 0) begin
					unexpected++;
					if (mismatches + unexpected <= 10)
						$display("unexpected sample %0d with nothing pending", sample);
				end else begin
					want = sample_q.pop_front();
					if (sample !== want) begin
						mismatches++;
						if (mismatches + unexpected <= 10)
							$display("sample %0d: expected %0d, got %0d",
								n_samples, want, sample);
					end
				end
			end
		end
	end

	// Watchdog: too many cycles with no transfer on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus-side view of which bank entries hold loaded data.
	logic g_written[64];
	logic [6:0] g_active;

	task automatic put(input mode_item_t it);
		if (it.op == OP_LOAD)
			g_written[it.idx] = 1'b1;
		item_q.push_back(it);
	endtask

	function automatic logic signed [31:0] rand_coef(input bit mild);
		if (mild)
			return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
		return $urandom;
	endfunction

	function automatic mode_item_t rand_load(input logic [5:0] idx);
		mode_item_t it;
		bit mild;
		it.op = OP_LOAD;
		it.idx = idx;
		mild = $urandom_range(0, 9) < 7;
		it.fsr = rand_coef(mild);
		it.fsi = rand_coef(mild);
		it.ssr = rand_coef(mild);
		it.ssi = rand_coef(mild);
		mild = $urandom_range(0, 9) < 7;
		it.fpr = rand_coef(mild);
		it.fpi = rand_coef(mild);
		it.spr = rand_coef(mild);
		it.spi = rand_coef(mild);
		// Mostly rising frequency with the index, sometimes anything at all.
		if ($urandom_range(0, 4) != 0)
			it.freq = 16'(idx * 1000 + $urandom_range(0, 999));
		else
			it.freq = 16'($urandom);
		it.crit = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic mode_item_t plain(input op_t op);
		mode_item_t it;
		it = rand_load(6'($urandom));
		it.op = op;
		return it;
	endfunction

	// Random items. A render that would walk into an unloaded entry becomes
	// a load of that entry instead.
	task automatic rand_items(input int count);
		int r, n, hole;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				put(rand_load(6'($urandom)));
			end else if (r < 20) begin
				put(plain(OP_RESTART));
			end else if (r < 24) begin
				put(plain(OP_NONE));
			end else begin
				n = (g_active > MAX_MODES) ? MAX_MODES : int'(g_active);
				hole = -1;
				for (int k = n - 1; k >= 0; k--)
					if (!g_written[k])
						hole = k;
				if (hole >= 0)
					put(rand_load(6'(hole)));
				else
					put(plain(OP_RENDER));
			end
		end
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_FREQ: p_lo_freq = data[15:0];
			REG_MAX_FREQ: p_hi_freq = data[15:0];
			REG_ACTIVE:   p_active = data[6:0];
			REG_SCALE:    p_gain = data[15:0];
			REG_PERIOD:   p_period = data;
			default: ;
		endcase
	endtask

	// Write all registers; only called while the block has nothing in flight.
	task automatic set_regs(input logic [15:0] lo, input logic [15:0] hi,
			input logic [6:0] act, input logic [15:0] gain, input logic [31:0] per);
		cfg_write(REG_MIN_FREQ, 32'(lo));
		cfg_write(REG_MAX_FREQ, 32'(hi));
		cfg_write(REG_ACTIVE, 32'(act));
		cfg_write(REG_SCALE, 32'(gain));
		cfg_write(REG_PERIOD, per);
		g_active = act;
	endtask

	// Let the sender run dry and wait for every expected sample, then let the
	// bank settle before the next register writes.
	task automatic drain();
		do @(posedge clk); while (item_q.size() != 0 || in_valid || sample_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		mode_item_t it;
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_FREQ;
		cfg_data = '0;
		cur = '{op: OP_NONE, default: '0};
		p_elapsed = '0;
		p_armed = 1'b0;
		foreach (g_written[k])
			g_written[k] = 1'b0;
		g_active = 7'd64;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: a small bank with a skipped mode and a walk stop.
		set_regs(16'd20, 16'd20000, 7'd4, 16'd256, 32'd22906492);
		put(plain(OP_RENDER)); // not armed yet, so no sample
		put(plain(OP_NONE));
		it = rand_load(6'd0);
		it.fsr = 32'sh7fffffff; it.fsi = 32'sh7fffffff;
		it.ssr = 32'sh7fffffff; it.ssi = 32'sh7fffffff;
		it.fpr = 32'sh7fffffff; it.fpi = 32'sh7fffffff;
		it.spr = 32'sh7fffffff; it.spi = 32'sh7fffffff;
		it.freq = 16'd20; it.crit = 1'b0;
		put(it);
		it = rand_load(6'd1);
		it.fsr = 32'sh80000000; it.fsi = 32'sh80000000;
		it.ssr = 32'sh80000000; it.ssi = 32'sh80000000;
		it.fpr = 32'sh80000000; it.fpi = 32'sh80000000;
		it.spr = 32'sh80000000; it.spi = 32'sh80000000;
		it.freq = 16'd20000; it.crit = 1'b1;
		put(it);
		it = rand_load(6'd2);
		it.freq = 16'd19; // below the band, skipped and not decayed
		put(it);
		it = rand_load(6'd3);
		it.freq = 16'hffff; // above the band, ends the walk
		put(it);
		put(plain(OP_RESTART));
		repeat (4) put(plain(OP_RENDER));
		put(plain(OP_RESTART));
		put(plain(OP_RENDER));
		it = rand_load(6'd63);
		it.crit = 1'b1;
		put(it);
		put(plain(OP_RENDER));
		put(plain(OP_NONE));
		put(plain(OP_RENDER));
		drain();

		// Random phases over several register settings, extremes among them.
		set_regs(16'd20, 16'd20000, 7'd8, 16'd256, 32'd22906492);
		rand_items(70);
		drain();
		calm = 1'b1; // a long stretch with no idling on either side
		set_regs(16'd0, 16'hffff, 7'd64, 16'hffff, 32'hffffffff);
		rand_items(110);
		drain();
		calm = 1'b0;
		set_regs(16'hffff, 16'd0, 7'd3, 16'd0, 32'd0);
		rand_items(40);
		drain();
		set_regs(16'd1000, 16'd5000, 7'd0, 16'd1, 32'd1);
		rand_items(25);
		drain();
		set_regs(16'd100, 16'd40000, 7'd127, 16'd300, $urandom);
		rand_items(110);
		drain();

		$display("ran %0d items and checked %0d samples over six register settings",
			n_items, n_samples);
		$display("%0d sample mismatches, %0d samples with nothing pending",
			mismatches, unexpected);
		if (mismatches == 0 && unexpected == 0 && sample_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
